/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the clocked assertions used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define FNMF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fnmf: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define FNMF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fnmf: next-cycle check failed");

`endif

/* rtl/fnmf_pkg.sv */
// ----------------------------------------------------------------------------
// fnmf_pkg
// Shared constants, register codes and the channel mean function for the
// four-neighbour mean filter.
// ----------------------------------------------------------------------------
package fnmf_pkg;

  localparam int PIX_W   = 24;
  localparam int CH_W    = 8;
  localparam int N_CH    = 3;
  localparam int CFG_W   = 12;
  localparam int SZ_W    = CFG_W + 1;   // clamped size, holds up to 8191
  localparam int COORD_W = 11;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // register index, taken from paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  // per-channel mean of four pixels, truncated
  function automatic logic [PIX_W-1:0] mean4(
    input logic [PIX_W-1:0] a,
    input logic [PIX_W-1:0] b,
    input logic [PIX_W-1:0] c,
    input logic [PIX_W-1:0] d
  );
    logic [PIX_W-1:0]  res;
    logic [CH_W+1:0]   s;
    res = '0;
    for (int k = 0; k < N_CH; k++) begin
      s = {2'b00, a[k*CH_W +: CH_W]} + {2'b00, b[k*CH_W +: CH_W]}
        + {2'b00, c[k*CH_W +: CH_W]} + {2'b00, d[k*CH_W +: CH_W]};
      res[k*CH_W +: CH_W] = s[CH_W+1:2];
    end
    return res;
  endfunction

endpackage

/* rtl/fnmf_stream_if.sv */
// ----------------------------------------------------------------------------
// fnmf_stream_if
// Valid/ready channels for input pixels and filtered results.
// ----------------------------------------------------------------------------
interface fnmf_in_if import fnmf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] in_pixel;
  logic             frame_start;

  modport source (output valid, output in_pixel, output frame_start, input ready);
  modport sink   (input valid, input in_pixel, input frame_start, output ready);
endinterface

interface fnmf_out_if import fnmf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   out_pixel;
  logic [COORD_W-1:0] out_col;
  logic [COORD_W-1:0] out_row;
  logic               frame_last;

  modport source (output valid, output out_pixel, output out_col, output out_row,
                  output frame_last, input ready);
  modport sink   (input valid, input out_pixel, input out_col, input out_row,
                  input frame_last, output ready);
endinterface

/* rtl/fnmf_ram.sv */
// ----------------------------------------------------------------------------
// fnmf_ram
// Generic single-write, single-read RAM with registered, enabled read.
// A read and write to one address in the same cycle returns the old data.
// ----------------------------------------------------------------------------
module fnmf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/four_neighbour_mean_filter_unit.sv */
// Pipeline: the line store is read into stage 1 at the accepting edge, and the
//   mean is registered into the output register as stage 1 advances.
// Throughput: one pixel per cycle, one line store read and one write per pixel.
//   A result held at the output stalls input after one more pixel.
// Reset: synchronous active-low; counters, taps and handshakes cleared, sizes
//   return to 640x480. Line store contents are not cleared.
// ----------------------------------------------------------------------------
// four_neighbour_mean_filter_unit
// Streams RGB pixels in row-major order and gives, for each interior pixel,
// the per-channel mean of its left, right, upper and lower neighbours.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module four_neighbour_mean_filter_unit import fnmf_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic              clk,
  input  logic              rst_n,
  fnmf_in_if.sink           in_s,
  fnmf_out_if.source        out_m,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam logic [SZ_W-1:0] MAXW = SZ_W'(MAX_WIDTH);
  localparam logic [SZ_W-1:0] MAXH = SZ_W'(MAX_HEIGHT);
  localparam logic [SZ_W-1:0] TWO  = SZ_W'(2);

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [CW-1:0]    col;
    logic [RW-1:0]    row;
    logic             hit;
    logic             last;
  } s1_t;

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] frame_width_r, frame_height_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  frame_width_r  <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_r);
      REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_r);
      default:          prdata = '0;
    endcase
  end

  // zero means one, large values saturate at MAX_WIDTH and MAX_HEIGHT
  logic [SZ_W-1:0] w_sz, h_sz;

  always_comb begin
    if (frame_width_r == '0)               w_sz = SZ_W'(1);
    else if (SZ_W'(frame_width_r) > MAXW)  w_sz = MAXW;
    else                                   w_sz = SZ_W'(frame_width_r);
    if (frame_height_r == '0)              h_sz = SZ_W'(1);
    else if (SZ_W'(frame_height_r) > MAXH) h_sz = MAXH;
    else                                   h_sz = SZ_W'(frame_height_r);
  end

  // ---------------- stage 0: position and store read ----------------
  logic [CW-1:0]   col_count_r, col_count_nxt;
  logic [RW-1:0]   row_count_r, row_count_nxt;
  logic [SZ_W-1:0] c_base, r_base, c0, r1, r2, c_inc, r_inc;
  logic            in_acc, s1_adv;

  assign in_acc = in_s.valid && in_s.ready;

  always_comb begin
    c_base = in_s.frame_start ? '0 : SZ_W'(col_count_r);
    r_base = in_s.frame_start ? '0 : SZ_W'(row_count_r);
    // width lowered mid-frame: wrap to the start of the next row
    if (c_base >= w_sz) begin
      c0 = '0;
      r1 = r_base + SZ_W'(1);
    end else begin
      c0 = c_base;
      r1 = r_base;
    end
    r2 = (r1 >= h_sz) ? '0 : r1;

    c_inc = c0 + SZ_W'(1);
    r_inc = r2 + SZ_W'(1);
    if (c_inc >= w_sz) begin
      col_count_nxt = '0;
      row_count_nxt = (r_inc >= h_sz) ? '0 : r_inc[RW-1:0];
    end else begin
      col_count_nxt = c_inc[CW-1:0];
      row_count_nxt = r2[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
    end else if (in_acc) begin
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
    end
  end

  // ---------------- stage 1: mean and write-back ----------------
  s1_t                s1_r;
  logic               s1_valid_r;
  logic               fwd_r;
  logic [2*PIX_W-1:0] fwd_data_r;
  logic [2*PIX_W-1:0] ram_rdata, rd_data, wr_data;
  logic [PIX_W-1:0]   near_v, far_v, mean_v;
  logic [PIX_W-1:0]   prev_pix_r, mid0_r, mid1_r, far_tap_r;
  logic               out_valid_r;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_m.ready);
  assign in_s.ready  = !s1_valid_r || s1_adv;

  // entry layout: far row in the upper half, near row in the lower half
  assign rd_data = fwd_r ? fwd_data_r : ram_rdata;
  assign near_v  = rd_data[PIX_W-1:0];
  assign far_v   = rd_data[2*PIX_W-1:PIX_W];
  assign wr_data = {near_v, s1_r.pix};
  assign mean_v  = mean4(mid1_r, near_v, far_tap_r, prev_pix_r);

  fnmf_ram #(
    .WIDTH (2*PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_r.col),
    .wdata (wr_data),
    .re    (in_acc),
    .raddr (c0[CW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        // same entry written this edge: the read returns stale data
        fwd_r      <= s1_adv && (s1_r.col == c0[CW-1:0]);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
        fwd_r      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.pix  <= in_s.in_pixel;
      s1_r.col  <= c0[CW-1:0];
      s1_r.row  <= r2[RW-1:0];
      s1_r.hit  <= (r2 >= TWO) && (c0 >= TWO);
      s1_r.last <= (r2 == h_sz - SZ_W'(1)) && (c0 == w_sz - SZ_W'(1));
    end
    if (s1_adv) begin
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pix_r <= '0;
      mid0_r     <= '0;
      mid1_r     <= '0;
      far_tap_r  <= '0;
    end else if (s1_adv) begin
      prev_pix_r <= s1_r.pix;
      mid0_r     <= near_v;
      mid1_r     <= mid0_r;
      far_tap_r  <= far_v;
    end
  end

  // ---------------- output register ----------------
  logic [PIX_W-1:0]   out_pixel_r;
  logic [COORD_W-1:0] out_col_r, out_row_r;
  logic               out_last_r;
  logic [SZ_W-1:0]    col_m1, row_m1;

  assign col_m1 = SZ_W'(s1_r.col) - SZ_W'(1);
  assign row_m1 = SZ_W'(s1_r.row) - SZ_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_r.hit;
    end else if (out_m.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_r.hit) begin
      out_pixel_r <= mean_v;
      out_col_r   <= col_m1[COORD_W-1:0];
      out_row_r   <= row_m1[COORD_W-1:0];
      out_last_r  <= s1_r.last;
    end
  end

  assign out_m.valid      = out_valid_r;
  assign out_m.out_pixel  = out_pixel_r;
  assign out_m.out_col    = out_col_r;
  assign out_m.out_row    = out_row_r;
  assign out_m.frame_last = out_last_r;

  // ---------------- checks ----------------
  `FNMF_ASSERT_NEXT(a_acc_fills_s1, in_acc, s1_valid_r)
  `FNMF_ASSERT_SAME(a_fwd_needs_item, fwd_r, s1_valid_r)
  `FNMF_ASSERT_SAME(a_hit_interior, s1_valid_r && s1_r.hit,
                    (SZ_W'(s1_r.col) >= TWO) && (SZ_W'(s1_r.row) >= TWO))
  `FNMF_ASSERT_NEXT(a_stall_holds_s1, s1_valid_r && !s1_adv,
                    s1_valid_r && $stable(s1_r))

endmodule

/* dv/tb_four_neighbour_mean_filter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_four_neighbour_mean_filter_unit
// Streams RGB frames of many sizes through the filter. The mean of the four
// neighbours is worked out whenever an accepted pixel closes an interior centre,
// and each result is checked in order. Source and sink idle and stall at random.
// ----------------------------------------------------------------------------
module tb_four_neighbour_mean_filter_unit;
  import fnmf_pkg::*;

  localparam int MAX_W         = 2048;
  localparam int MAX_H         = 2048;
  localparam int RESET_WIDTH   = 640;
  localparam int RESET_HEIGHT  = 480;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int RAND_PIXELS   = 360;
  localparam int LONG_HOLD     = 300;

  // 3x3 frame, centre and corners full scale, lower neighbour zero
  localparam bit [PIX_W-1:0] CROSS_PAT [9] = '{
    24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
    24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
    24'hFFFFFF, 24'h000000, 24'hFFFFFF
  };
  // channel sums of 4, 5 and 7, all truncate to 1
  localparam bit [PIX_W-1:0] TRUNC_PAT [9] = '{
    24'h000000, 24'h000000, 24'h000000,
    24'h070503, 24'hFFFFFF, 24'h000001,
    24'h000000, 24'h000000, 24'h000000
  };

  typedef struct {
    bit [PIX_W-1:0] pixel;
    bit             sof;
  } pixel_item_t;

  typedef struct {
    bit [PIX_W-1:0]   pixel;
    bit [COORD_W-1:0] col;
    bit [COORD_W-1:0] row;
    bit               last;
  } mean_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  fnmf_in_if  in_ch ();
  fnmf_out_if out_ch ();

  four_neighbour_mean_filter_unit #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_s    (in_ch),
    .out_m   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // filter state mirrored for prediction
  bit [CFG_W-1:0] width_reg;
  bit [CFG_W-1:0] height_reg;
  bit [PIX_W-1:0] near_line [MAX_W];
  bit [PIX_W-1:0] far_line [MAX_W];
  bit [PIX_W-1:0] mid_tap [2];
  bit [PIX_W-1:0] far_tap;
  bit [PIX_W-1:0] last_pix;
  int unsigned    col_pos;
  int unsigned    row_pos;

  pixel_item_t  pixel_feed_q [$];
  mean_result_t mean_expect_q [$];

  int  fed_cnt;
  int  taken_cnt;
  int  result_cnt;
  int  frame_end_cnt;
  int  size_cnt;
  int  err_cnt;
  int  stall_cycles;
  int  src_gap;
  int  rdy_gap;
  int  sink_hold;
  bit  burst_mode;
  bit  px_accepted;

  function automatic int unsigned eff_size(input bit [CFG_W-1:0] v, input int unsigned cap);
    if (v == 0) return 1;
    if (v > cap) return cap;
    return 32'(v);
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit [PIX_W-1:0] rand_pixel();
    bit [PIX_W-1:0] p;
    p = PIX_W'($urandom());
    for (int k = 0; k < N_CH; k++) begin
      case ($urandom_range(0, 9))
        0: p[k*CH_W +: CH_W] = '0;
        1: p[k*CH_W +: CH_W] = '1;
        default: ;
      endcase
    end
    return p;
  endfunction

  // one pixel through the filter: position update, mean of the cross, line stores
  task automatic predict_mean(input bit [PIX_W-1:0] pix, input bit sof);
    int unsigned   w_eff;
    int unsigned   h_eff;
    int unsigned   c;
    int unsigned   r;
    bit [PIX_W-1:0] up_pix;
    bit [PIX_W-1:0] up2_pix;
    bit [CH_W+1:0]  acc;
    mean_result_t   res;
    w_eff = eff_size(width_reg, MAX_W);
    h_eff = eff_size(height_reg, MAX_H);
    if (sof) begin
      col_pos = 0;
      row_pos = 0;
    end
    // size lowered under the running position
    if (col_pos >= w_eff) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h_eff) row_pos = 0;
    c = col_pos;
    r = row_pos;
    up_pix  = near_line[c];
    up2_pix = far_line[c];
    if (r >= 2 && c >= 2) begin
      // centre is (r-1, c-1): left, right, upper, lower
      for (int k = 0; k < N_CH; k++) begin
        acc = {2'b00, mid_tap[1][k*CH_W +: CH_W]} + {2'b00, up_pix[k*CH_W +: CH_W]}
            + {2'b00, far_tap[k*CH_W +: CH_W]} + {2'b00, last_pix[k*CH_W +: CH_W]};
        res.pixel[k*CH_W +: CH_W] = acc[CH_W+1:2];
      end
      res.col  = COORD_W'(c - 1);
      res.row  = COORD_W'(r - 1);
      res.last = (r == h_eff - 1) && (c == w_eff - 1);
      mean_expect_q.push_back(res);
    end
    mid_tap[1]   = mid_tap[0];
    mid_tap[0]   = up_pix;
    far_tap      = up2_pix;
    far_line[c]  = up_pix;
    near_line[c] = pix;
    last_pix     = pix;
    col_pos = c + 1;
    if (col_pos >= w_eff) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h_eff) row_pos = 0;
    end
  endtask

  task automatic push_pixel(input bit [PIX_W-1:0] pix, input bit sof);
    pixel_feed_q.push_back('{pixel: pix, sof: sof});
    fed_cnt++;
  endtask

  task automatic push_random(input int unsigned n, input bit sof_first);
    for (int unsigned i = 0; i < n; i++) push_pixel(rand_pixel(), sof_first && (i == 0));
  endtask

  // all items in, all results out, then let the pipeline run dry
  task automatic wait_idle();
    do @(negedge clk); while (!(taken_cnt == fed_cnt && mean_expect_q.size() == 0));
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic idx, input logic [DATA_W-1:0] data,
                            output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_reg(input logic idx, input bit [CFG_W-1:0] exp_val);
    logic [DATA_W-1:0] rd;
    apb_access(1'b0, idx, '0, rd);
    if (rd !== DATA_W'(exp_val)) begin
      err_cnt++;
      $display("%0t: register %0d readback: expected %0h, got %0h", $time, idx, exp_val, rd);
    end
  endtask

  task automatic set_frame_size(input bit [DATA_W-1:0] w_val, input bit [DATA_W-1:0] h_val);
    logic [DATA_W-1:0] rd;
    wait_idle();
    apb_access(1'b1, REG_FRAME_WIDTH, w_val, rd);
    width_reg = w_val[CFG_W-1:0];
    apb_access(1'b1, REG_FRAME_HEIGHT, h_val, rd);
    height_reg = h_val[CFG_W-1:0];
    check_reg(REG_FRAME_WIDTH, width_reg);
    check_reg(REG_FRAME_HEIGHT, height_reg);
    size_cnt++;
  endtask

  // pixel source: holds an offered item until taken
  always @(negedge clk) begin
    pixel_item_t cur;
    if (!in_ch.valid || px_accepted) begin
      if (src_gap > 0) begin
        in_ch.valid <= 1'b0;
        src_gap--;
      end else if (pixel_feed_q.size() > 0) begin
        cur = pixel_feed_q.pop_front();
        in_ch.in_pixel    <= cur.pixel;
        in_ch.frame_start <= cur.sof;
        in_ch.valid       <= 1'b1;
        src_gap = pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result sink: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      out_ch.ready <= 1'b0;
      sink_hold--;
    end else if (rdy_gap > 0) begin
      out_ch.ready <= 1'b0;
      rdy_gap--;
    end else begin
      out_ch.ready <= 1'b1;
      rdy_gap = pick_gap();
    end
  end

  always @(posedge clk) begin
    mean_result_t exp_res;
    if (!rst_n) begin
      px_accepted = 1'b0;
    end else begin
      px_accepted = in_ch.valid && in_ch.ready;
      if (px_accepted) begin
        predict_mean(in_ch.in_pixel, in_ch.frame_start);
        taken_cnt++;
      end
      if (out_ch.valid && out_ch.ready) begin
        result_cnt++;
        if (out_ch.frame_last === 1'b1) frame_end_cnt++;
        if (mean_expect_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result: pixel %06h col %0d row %0d last %0b", $time,
                   out_ch.out_pixel, out_ch.out_col, out_ch.out_row, out_ch.frame_last);
        end else begin
          exp_res = mean_expect_q.pop_front();
          if (out_ch.out_pixel !== exp_res.pixel) begin
            err_cnt++;
            $display("%0t: out_pixel: expected %06h, got %06h", $time,
                     exp_res.pixel, out_ch.out_pixel);
          end
          if (out_ch.out_col !== exp_res.col) begin
            err_cnt++;
            $display("%0t: out_col: expected %0d, got %0d", $time, exp_res.col, out_ch.out_col);
          end
          if (out_ch.out_row !== exp_res.row) begin
            err_cnt++;
            $display("%0t: out_row: expected %0d, got %0d", $time, exp_res.row, out_ch.out_row);
          end
          if (out_ch.frame_last !== exp_res.last) begin
            err_cnt++;
            $display("%0t: frame_last: expected %0b, got %0b", $time,
                     exp_res.last, out_ch.frame_last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("no item moved for %0d cycles, %0d results outstanding",
               stall_cycles, mean_expect_q.size());
      $display("[four_neighbour_mean_filter_unit] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned       rand_cnt;
    int unsigned       w;
    int unsigned       h;
    int unsigned       w_eff;
    int unsigned       h_eff;
    int unsigned       n_px;
    int unsigned       n_frames;
    bit [DATA_W-1:0]   w_val;
    bit [DATA_W-1:0]   h_val;

    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    in_ch.valid       = 1'b0;
    in_ch.in_pixel    = '0;
    in_ch.frame_start = 1'b0;
    out_ch.ready      = 1'b0;
    width_reg  = CFG_W'(RESET_WIDTH);
    height_reg = CFG_W'(RESET_HEIGHT);
    burst_mode = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // reset size: opening pixels of the first row
    check_reg(REG_FRAME_WIDTH, CFG_W'(RESET_WIDTH));
    check_reg(REG_FRAME_HEIGHT, CFG_W'(RESET_HEIGHT));
    push_random(24, 1'b1);

    // smallest frame: full scale, neighbour cross, truncation after wrap
    set_frame_size(3, 3);
    for (int i = 0; i < 9; i++) push_pixel('1, i == 0);
    for (int i = 0; i < 9; i++) push_pixel(CROSS_PAT[i], i == 0);
    for (int i = 0; i < 9; i++) push_pixel(TRUNC_PAT[i], 1'b0);

    // zero, masked-off and sub-3 sizes: no interior pixels
    set_frame_size(32'h0000_1000, 0);
    push_random(10, 1'b1);
    set_frame_size(2, 5);
    push_random(12, 1'b1);
    set_frame_size(5, 2);
    push_random(12, 1'b1);

    // shrink width, then height, under a running frame
    set_frame_size(8, 6);
    push_random(30, 1'b1);
    set_frame_size(4, 6);
    push_random(6, 1'b0);
    set_frame_size(4, 4);
    push_random(12, 1'b0);

    // saturated width and height, a partial frame each
    set_frame_size(32'h0000_0FFF, 3);
    push_random(16, 1'b1);
    set_frame_size(3, 32'h0000_0FFF);
    push_random(24, 1'b1);

    // receiver holds off while the source streams, so the block backs up
    set_frame_size(6, 5);
    burst_mode = 1'b1;
    push_random(60, 1'b1);
    sink_hold = LONG_HOLD;

    rand_cnt = 0;
    while (rand_cnt < RAND_PIXELS) begin
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(0, 2);
        1, 2:    w = $urandom_range(11, 24);
        default: w = $urandom_range(3, 10);
      endcase
      case ($urandom_range(0, 9))
        0:       h = $urandom_range(0, 2);
        1, 2:    h = $urandom_range(7, 10);
        default: h = $urandom_range(3, 6);
      endcase
      // junk above the register width is dropped by the block
      w_val = w;
      h_val = h;
      if ($urandom_range(0, 3) == 0) w_val[DATA_W-1:CFG_W] = $urandom();
      if ($urandom_range(0, 3) == 0) h_val[DATA_W-1:CFG_W] = $urandom();
      set_frame_size(w_val, h_val);
      burst_mode = ($urandom_range(0, 3) == 0);
      w_eff = eff_size(w_val[CFG_W-1:0], MAX_W);
      h_eff = eff_size(h_val[CFG_W-1:0], MAX_H);
      n_frames = $urandom_range(1, 3);
      for (int unsigned f = 0; f < n_frames && rand_cnt < RAND_PIXELS; f++) begin
        case ($urandom_range(0, 9))
          0: begin
            // cut short, the next frame restarts it
            n_px = $urandom_range(1, w_eff * h_eff);
            push_random(n_px, 1'b1);
          end
          1: begin
            // back-to-back frame relying on counter wrap
            n_px = w_eff * h_eff;
            push_random(n_px, f == 0);
          end
          default: begin
            n_px = w_eff * h_eff;
            push_random(n_px, 1'b1);
          end
        endcase
        if (w_eff >= 3 && h_eff >= 3) rand_cnt += n_px;
      end
    end

    wait_idle();
    $display("ran %0d pixels over %0d frame sizes, incl. zero, saturated and mid-frame shrink",
             taken_cnt, size_cnt);
    $display("checked %0d filtered pixels, %0d of them frame ends", result_cnt, frame_end_cnt);
    if (err_cnt == 0 && mean_expect_q.size() == 0) begin
      $display("[four_neighbour_mean_filter_unit] OK");
    end else begin
      $display("[four_neighbour_mean_filter_unit] ERROR");
    end
    $finish;
  end

endmodule
